// File: sv/bpa_pkg.sv
// bpa_pkg: shared types, constants and codes of the bitmap page allocator
// depends on nothing; imported by every module of the block
package bpa_pkg;

    localparam int PG_W          = 13;
    localparam int PID_W         = 12;
    localparam int WORD_SHIFT    = 3 + 2;
    localparam int WORD_BITS     = 1 << WORD_SHIFT;
    localparam int WNUM_W        = PG_W - WORD_SHIFT;
    localparam int MAX_PAGES_DEF = 4096;

    localparam logic [PG_W-1:0] PAGE_COUNT_RST = PG_W'(4096);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [PID_W-1:0] page_id;
    } t_in;

    typedef struct packed {
        logic [PID_W-1:0] result_page;
        t_status          status;
    } t_out;

    typedef struct packed {
        logic                  found;
        logic                  last;
        logic [WORD_SHIFT-1:0] off;
    } t_scan;

endpackage

// File: sv/bpa_map_ram.sv
// bpa_map_ram: used-bit memory, one write port and one read port
// read data registered; uses bpa_pkg for the word width
module bpa_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [bpa_pkg::WORD_BITS-1:0]  o_rdata
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bpa_scan.sv
// bpa_scan: lowest clear bit of one bitmap word inside [start, lim)
// combinational; uses bpa_pkg types
module bpa_scan (
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bpa_pkg::WNUM_W-1:0]    i_wnum,
    input  logic [bpa_pkg::PG_W-1:0]      i_start,
    input  logic [bpa_pkg::PG_W-1:0]      i_lim,
    output bpa_pkg::t_scan                o_scan
);
    import bpa_pkg::*;

    logic [PG_W-1:0]       lim_m1;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_SHIFT-1:0] off;
    logic                  first_w;
    logic                  last_w;

    assign lim_m1  = i_lim - PG_W'(1);
    assign first_w = (i_wnum == i_start[PG_W-1:WORD_SHIFT]);
    assign last_w  = (i_wnum == lim_m1[PG_W-1:WORD_SHIFT]);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = !i_word[b]
                && (!first_w || (WORD_SHIFT'(b) >= i_start[WORD_SHIFT-1:0]))
                && (!last_w  || (WORD_SHIFT'(b) <= lim_m1[WORD_SHIFT-1:0]));
        end
    end

    // priority encoder, lowest bit wins
    always_comb begin
        off = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                off = WORD_SHIFT'(b);
            end
        end
    end

    assign o_scan.found = |cand;
    assign o_scan.last  = last_w;
    assign o_scan.off   = off;

endmodule

// File: sv/bitmap_page_allocator_unit.sv
// bitmap_page_allocator_unit: top level, request sequencer around the bitmap memory
// depends on bpa_pkg, bpa_map_ram and bpa_scan
// A free in range is accepted with the read of the bitmap word, then writes the word back,
// then loads the output register. An allocate reads one 32-page word of the bitmap memory
// per scan step, from the word of the search start up to the word holding the found page
// (at most up to the last word below the lesser of page_count and MAX_PAGES), then loads
// the output register. A free out of range, or an allocate whose search start is at or past
// that lesser bound, goes from the accept straight to the load of the output register.
// The load of the output register waits while a stalled result still holds it. One request
// is worked on at a time; the next one is taken while the result of the last still waits
// in the output register. After reset a clearing pass writes every bitmap word in turn,
// during which no request is taken; page_count writes are taken at any time.
module bitmap_page_allocator_unit #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  bpa_pkg::t_in            i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output bpa_pkg::t_out           o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [bpa_pkg::PG_W-1:0] i_cfg_data
);
    import bpa_pkg::*;

    localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [PG_W-1:0]      r_page_count, n_page_count;
    logic [PG_W-1:0]      r_start, n_start;
    logic [PID_W-1:0]     r_pid, n_pid;
    logic [WNUM_W-1:0]    r_wptr, n_wptr;
    t_out                 r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic [PG_W-1:0]      lim;
    logic                 in_acc;
    logic                 out_free;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    t_scan                scan;
    logic [PG_W-1:0]      found_page;
    logic [WNUM_W-1:0]    pid_word;
    logic [WNUM_W-1:0]    in_pid_word;

    assign lim = (32'(r_page_count) < MAX_PAGES) ? r_page_count : PG_W'(MAX_PAGES);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign found_page  = {r_wptr, scan.off};
    assign pid_word    = WNUM_W'(r_pid >> WORD_SHIFT);
    assign in_pid_word = WNUM_W'(i_in_data.page_id >> WORD_SHIFT);

    bpa_map_ram #(
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bpa_scan u_scan (
        .i_word  (mem_rdata),
        .i_wnum  (r_wptr),
        .i_start (r_start),
        .i_lim   (lim),
        .o_scan  (scan)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_page_count = r_page_count;
        n_start      = r_start;
        n_pid        = r_pid;
        n_wptr       = r_wptr;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = AW'(r_wptr);
        mem_wdata    = mem_rdata;
        mem_raddr    = AW'(r_wptr);

        if (i_cfg_valid) begin
            n_page_count = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_pid = i_in_data.page_id;
                    if (i_in_data.op == OP_FREE) begin
                        if ({1'b0, i_in_data.page_id} < lim) begin
                            n_wptr    = in_pid_word;
                            mem_raddr = AW'(in_pid_word);
                            n_state   = S_FREE;
                        end else begin
                            n_res   = '{result_page: i_in_data.page_id, status: ST_RANGE};
                            n_state = S_DONE;
                        end
                    end else begin
                        if (r_start < lim) begin
                            n_wptr    = r_start[PG_W-1:WORD_SHIFT];
                            mem_raddr = AW'(r_start[PG_W-1:WORD_SHIFT]);
                            n_state   = S_SCAN;
                        end else begin
                            n_res   = '{result_page: '0, status: ST_FULL};
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan.found) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | (WORD_BITS'(1) << scan.off);
                    if (found_page == r_start) begin
                        n_start = r_start + PG_W'(1);
                    end
                    n_res   = '{result_page: found_page[PID_W-1:0], status: ST_OK};
                    n_state = S_DONE;
                end else if (scan.last) begin
                    n_res   = '{result_page: '0, status: ST_FULL};
                    n_state = S_DONE;
                end else begin
                    n_wptr    = r_wptr + WNUM_W'(1);
                    mem_raddr = AW'(r_wptr + WNUM_W'(1));
                end
            end
            S_FREE: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~(WORD_BITS'(1) << r_pid[WORD_SHIFT-1:0]);
                n_start   = {1'b0, r_pid};
                n_res     = '{result_page: r_pid, status: ST_OK};
                n_state   = S_DONE;
                if (pid_word != r_wptr) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_page_count <= PAGE_COUNT_RST;
            r_start      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_page_count <= n_page_count;
            r_start      <= n_start;
            r_out_valid  <= n_out_valid;
        end
        r_pid  <= n_pid;
        r_wptr <= n_wptr;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    a_acc_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN || r_state == S_FREE || r_state == S_DONE))
        else $error("request transfer not followed by a work state");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside the done state");

    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan.found) |-> (found_page >= r_start && found_page < lim))
        else $error("allocated page outside the search window");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_start < lim && r_wptr >= r_start[PG_W-1:WORD_SHIFT]))
        else $error("scan running with a bad start or word pointer");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for bitmap_page_allocator_unit, with a bitmap predictor,
// queue-fed request driver, result monitor and config writer across page-count settings
// depends on bpa_pkg and the bitmap_page_allocator_unit rtl
module tb_top;
    import bpa_pkg::*;

    localparam int N_PAGES   = MAX_PAGES_DEF;
    localparam int QUIET_CAP = 4000;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    t_in             in_data   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out            out_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [PG_W-1:0] cfg_data  = '0;

    logic            page_used [N_PAGES];
    logic [PG_W-1:0] next_try;
    logic [PG_W-1:0] pages_cfg;

    t_in             req_backlog [$];
    t_out            reply_due [$];
    logic [PG_W-1:0] cfg_backlog [$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int n_sent          = 0;
    int n_checked       = 0;
    int n_cfg_sent      = 0;
    int n_cfg_done      = 0;
    int n_settings      = 0;
    int n_fail          = 0;
    int quiet_cycles    = 0;

    bitmap_page_allocator_unit #(
        .MAX_PAGES(N_PAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out serve_request(t_in req);
        t_out res;
        int   lim;
        int   pg;
        lim = (int'(pages_cfg) < N_PAGES) ? int'(pages_cfg) : N_PAGES;
        res.result_page = req.page_id;
        res.status      = ST_OK;
        if (req.op == OP_ALLOC) begin
            pg = int'(next_try);
            while (pg < lim && page_used[pg]) pg++;
            if (pg < lim) begin
                page_used[pg] = 1'b1;
                if (pg == int'(next_try)) next_try = PG_W'(pg + 1);
                res.result_page = PID_W'(pg);
            end else begin
                res.result_page = '0;
                res.status      = ST_FULL;
            end
        end else if (int'(req.page_id) < lim) begin
            page_used[req.page_id] = 1'b0;
            next_try = PG_W'(req.page_id);
        end else begin
            res.status = ST_RANGE;
        end
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic took;
        took = in_valid && !in_stall;
        if (took) begin
            reply_due.push_back(serve_request(in_data));
        end
        if (!in_valid || took) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_data  <= req_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // page_count writer
    always @(posedge i_clk) begin
        logic took;
        took = cfg_valid && cfg_ready;
        if (took) begin
            pages_cfg = cfg_data;
            n_cfg_done++;
        end
        if (!cfg_valid || took) begin
            if (cfg_backlog.size() > 0) begin
                cfg_data  <= cfg_backlog.pop_front();
                cfg_valid <= 1'b1;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (out_valid && !out_stall) begin
            if (reply_due.size() == 0) begin
                $error("unexpected result: result_page %0d status %0d",
                       out_data.result_page, out_data.status);
                n_fail++;
            end else begin
                want = reply_due.pop_front();
                if (out_data.result_page !== want.result_page) begin
                    $error("result_page expected %0d actual %0d",
                           want.result_page, out_data.result_page);
                    n_fail++;
                end
                if (out_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // watchdog on transfers while work is outstanding
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || (n_checked >= n_sent && cfg_backlog.size() == 0 && !cfg_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_CAP) begin
            $error("no transfer for %0d cycles", QUIET_CAP);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(t_op op, int pid);
        t_in req;
        req.op      = op;
        req.page_id = PID_W'(pid);
        req_backlog.push_back(req);
        n_sent++;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (n_checked < n_sent);
    endtask

    task automatic set_pages(int v);
        cfg_backlog.push_back(PG_W'(v));
        n_cfg_sent++;
        do @(posedge i_clk); while (n_cfg_done < n_cfg_sent);
        n_settings++;
    endtask

    task automatic run_mix(int pages, int n, int s_idle, int r_stall);
        int lim;
        int pid;
        set_pages(pages);
        sender_idle_pct = s_idle;
        stall_pct       = r_stall;
        lim = (pages < N_PAGES) ? pages : N_PAGES;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) settle();
            if ($urandom_range(99) < 55) begin
                send(OP_ALLOC, $urandom_range(4095));
            end else begin
                if (lim > 0 && $urandom_range(99) < 75) pid = $urandom_range(lim - 1);
                else pid = $urandom_range(4095);
                send(OP_FREE, pid);
            end
        end
        settle();
    endtask

    initial begin
        int mix_pages [13];
        int idle_mix  [4];
        int stall_mix [4];
        mix_pages = '{4096, 1, 8191, 40, 64, 33, 200, 7, 1000, 0, 4095, 128, 4096};
        idle_mix  = '{0, 88, 0, 10};
        stall_mix = '{0, 0, 88, 10};
        for (int p = 0; p < N_PAGES; p++) page_used[p] = 1'b0;
        next_try  = '0;
        pages_cfg = PAGE_COUNT_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count: sequential allocs, refill of a freed page, top page, start past top
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        send(OP_FREE, 1);
        send(OP_ALLOC, 4095);
        send(OP_FREE, 4095);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        send(OP_FREE, 0);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        settle();
        // count above the cap
        set_pages(8191);
        send(OP_FREE, 4095);
        settle();
        // tiny count: out of range frees, start past count, full
        set_pages(3);
        send(OP_FREE, 3);
        send(OP_FREE, 4095);
        send(OP_ALLOC, 0);
        send(OP_FREE, 2);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        send(OP_FREE, 0);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 0);
        settle();
        // zero count
        set_pages(0);
        send(OP_ALLOC, 0);
        send(OP_FREE, 0);
        settle();

        for (int ph = 0; ph < 13; ph++) begin
            run_mix(mix_pages[ph], 79, idle_mix[ph % 4], stall_mix[ph % 4]);
        end
        sender_idle_pct = 0;
        stall_pct       = 0;
        settle();
        repeat (200) @(posedge i_clk);

        $display("tb: %0d requests checked across %0d page-count settings,", n_checked,
                 n_settings);
        $display("tb: with sender gaps and receiver stalls from none to 88 percent");
        if (n_fail == 0 && reply_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
